// File: hw/rtl/assert_macros.svh
// assertion macros shared by the bounding cylinder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VBC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define VBC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define VBC_ASSERT(lbl, clk, rst, prop)
`define VBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/vbc_pkg.sv
// shared types and constants of the bounding cylinder block
`default_nettype none
package vbc_pkg;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   typedef struct packed {
      logic                 not_empty;
      logic [QCNT_BITS-1:0] count;
   } q_status_type;
endpackage
`default_nettype wire

// File: hw/rtl/vertex_bounding_cylinder.sv
// top level of the streaming vertex bounding cylinder block
//
//  channel  direction  tdata fields (low bit up)                       tlast
//  req      in         vert_x, vert_y, vert_z                          last_vertex
//  rsp      out        lowest_y, highest_y, radius, bottom_edge,       none
//                      top_edge, max_depth
//
// vertices are taken one per cycle while req_tready is high; squares are formed in the
// accept cycle and folded into the running extremes the cycle after
// a last vertex leaves a summary in a four-entry queue; the back end then takes it
// through a single shared root unit, one root bit per cycle
// the intake stalls when queued plus in-flight summaries reach four; a held result
// blocks the back end; reset is synchronous and clears all control state
`default_nettype none
module vertex_bounding_cylinder #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // vert_x, vert_y, vert_z
   input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]  req_tdata,
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // lowest_y, highest_y, radius, bottom_edge, top_edge, max_depth
   output logic [((6*COORD_BITS+7)/8)*8-1:0]       rsp_tdata
);
   vbc_pkg::q_status_type         q_status;
   logic                          push_valid;
   logic [4*COORD_BITS-1:0]       push_data;
   logic [4*COORD_BITS-1:0]       head_data;
   logic                          pop;

   vbc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   vbc_queue #(.DATA_BITS(4*COORD_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (head_data),
      .status     (q_status)
   );

   vbc_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire

// File: hw/rtl/vbc_queue.sv
// short queue of per-model summaries between front and back
`default_nettype none
`include "assert_macros.svh"
module vbc_queue #(
   parameter int DATA_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire logic [DATA_BITS-1:0] push_data,
   input  wire logic                 pop,
   output logic [DATA_BITS-1:0]      pop_data,
   output vbc_pkg::q_status_type     status
);
   logic [DATA_BITS-1:0]          entry_ff [vbc_pkg::QUEUE_DEPTH];
   logic [vbc_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vbc_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vbc_pkg::QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_valid ? vbc_pkg::QPTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? vbc_pkg::QPTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      priority if (push_valid && !pop) begin
         count_in = vbc_pkg::QCNT_BITS'(count_ff + 1'b1);
      end else if (pop && !push_valid) begin
         count_in = vbc_pkg::QCNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data         = entry_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);

   `VBC_ASSERT(a_no_overflow, clock, reset,
      (count_ff == vbc_pkg::QCNT_BITS'(vbc_pkg::QUEUE_DEPTH)) |-> (!push_valid || pop))
   `VBC_ASSERT(a_no_underflow, clock, reset, pop |-> (count_ff != '0))
endmodule
`default_nettype wire

// File: hw/rtl/vbc_front.sv
// vertex intake: squares, running y extremes and greatest radius squared
`default_nettype none
`include "assert_macros.svh"
module vbc_front #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]    req_tdata,
   input  wire logic                                 req_tlast,
   input  wire vbc_pkg::q_status_type                q_status,
   output logic                                      push_valid,
   output logic [4*COORD_BITS-1:0]                   push_data
);
   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int CNT_WIDE = vbc_pkg::QCNT_BITS + 1;

   logic signed [COORD_BITS-1:0] vx, vy, vz;
   logic signed [SQ_BITS-1:0]    xsq_prod, zsq_prod;
   logic                         req_take;

   logic                         valid_b_ff, valid_b_in;
   logic                         last_b_ff;
   logic signed [COORD_BITS-1:0] y_b_ff;
   logic [SQ_BITS-1:0]           xsq_b_ff, zsq_b_ff;

   logic signed [COORD_BITS-1:0] min_acc_ff, min_acc_in, min_new;
   logic signed [COORD_BITS-1:0] max_acc_ff, max_acc_in, max_new;
   logic [SQ_BITS-1:0]           rsq_acc_ff, rsq_acc_in, rsq_new, rsq_sum;

   localparam logic signed [COORD_BITS-1:0] MIN_RESET = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] MAX_RESET = {1'b1, {(COORD_BITS-1){1'b0}}};

   assign vx = req_tdata[COORD_BITS-1:0];
   assign vy = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign vz = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign xsq_prod = vx * vx;
   assign zsq_prod = vz * vz;

   // room for a last vertex already in flight plus one more
   assign req_tready = (CNT_WIDE'(q_status.count) + CNT_WIDE'(valid_b_ff & last_b_ff))
                       < CNT_WIDE'(vbc_pkg::QUEUE_DEPTH);
   assign req_take   = req_tvalid & req_tready;
   assign valid_b_in = req_take;

   always_comb begin
      rsq_sum = xsq_b_ff + zsq_b_ff;
      min_new = (y_b_ff < min_acc_ff) ? y_b_ff : min_acc_ff;
      max_new = (y_b_ff > max_acc_ff) ? y_b_ff : max_acc_ff;
      rsq_new = (rsq_sum > rsq_acc_ff) ? rsq_sum : rsq_acc_ff;
      min_acc_in = min_acc_ff;
      max_acc_in = max_acc_ff;
      rsq_acc_in = rsq_acc_ff;
      if (valid_b_ff) begin
         if (last_b_ff) begin
            min_acc_in = MIN_RESET;
            max_acc_in = MAX_RESET;
            rsq_acc_in = '0;
         end else begin
            min_acc_in = min_new;
            max_acc_in = max_new;
            rsq_acc_in = rsq_new;
         end
      end
   end

   assign push_valid = valid_b_ff & last_b_ff;
   assign push_data  = {rsq_new, max_new, min_new};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
         min_acc_ff <= MIN_RESET;
         max_acc_ff <= MAX_RESET;
         rsq_acc_ff <= '0;
      end else begin
         valid_b_ff <= valid_b_in;
         min_acc_ff <= min_acc_in;
         max_acc_ff <= max_acc_in;
         rsq_acc_ff <= rsq_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         last_b_ff <= req_tlast;
         y_b_ff    <= vy;
         xsq_b_ff  <= $unsigned(xsq_prod);
         zsq_b_ff  <= $unsigned(zsq_prod);
      end
   end

   `VBC_ASSERT(a_last_clears_radius, clock, reset,
      (valid_b_ff && last_b_ff) |=> (rsq_acc_ff == '0))
   `VBC_ASSERT(a_take_reaches_stage, clock, reset, req_take |=> valid_b_ff)
endmodule
`default_nettype wire

// File: hw/rtl/vbc_back.sv
// result engine: y squares, shared digit-by-digit root unit, result register
`default_nettype none
`include "assert_macros.svh"
module vbc_back #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire vbc_pkg::q_status_type                q_status,
   input  wire logic [4*COORD_BITS-1:0]              head_data,
   output logic                                      pop,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [((6*COORD_BITS+7)/8)*8-1:0]         rsp_tdata
);
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int REM_BITS  = COORD_BITS + 2;
   localparam int OUT_BITS  = ((6*COORD_BITS+7)/8)*8;
   localparam int STEP_BITS = $clog2(COORD_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(COORD_BITS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SQUARE, ST_ROOT, ST_DELIVER} state_type;
   typedef enum logic [1:0] {PH_RADIUS, PH_BOTTOM, PH_TOP} phase_type;

   state_type                    state_ff, state_in;
   phase_type                    phase_ff, phase_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic [SQ_BITS-1:0]           operand_ff, operand_in;
   logic [REM_BITS-1:0]          rem_ff, rem_in;
   logic [COORD_BITS-1:0]        root_ff, root_in;
   logic signed [COORD_BITS-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic [SQ_BITS-1:0]           rsq_ff, rsq_in;
   logic [SQ_BITS-1:0]           bot_sq_ff, bot_sq_in, top_sq_ff, top_sq_in;
   logic [COORD_BITS-1:0]        radius_ff, radius_in, bot_ff, bot_in, top_ff, top_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_low_ff, rsp_low_in, rsp_high_ff, rsp_high_in;
   logic [COORD_BITS-1:0]        rsp_radius_ff, rsp_radius_in;
   logic [COORD_BITS-1:0]        rsp_bot_ff, rsp_bot_in, rsp_top_ff, rsp_top_in;
   logic [COORD_BITS-1:0]        rsp_depth_ff, rsp_depth_in;

   logic signed [SQ_BITS-1:0]    bot_prod, top_prod;
   logic [REM_BITS+1:0]          rem_shift, trial, rem_diff;
   logic                         take;
   logic [REM_BITS-1:0]          rem_next;
   logic [COORD_BITS-1:0]        root_next;

   assign bot_prod  = min_y_ff * min_y_ff;
   assign top_prod  = max_y_ff * max_y_ff;

   // one root bit per cycle from the top two operand bits
   assign rem_shift = {rem_ff, operand_ff[SQ_BITS-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign take      = rem_shift >= trial;
   assign rem_diff  = take ? (rem_shift - trial) : rem_shift;
   assign rem_next  = rem_diff[REM_BITS-1:0];
   assign root_next = {root_ff[COORD_BITS-2:0], take};

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      operand_in    = operand_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      min_y_in      = min_y_ff;
      max_y_in      = max_y_ff;
      rsq_in        = rsq_ff;
      bot_sq_in     = bot_sq_ff;
      top_sq_in     = top_sq_ff;
      radius_in     = radius_ff;
      bot_in        = bot_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_radius_in = rsp_radius_ff;
      rsp_bot_in    = rsp_bot_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      pop           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               pop      = 1'b1;
               min_y_in = head_data[COORD_BITS-1:0];
               max_y_in = head_data[2*COORD_BITS-1:COORD_BITS];
               rsq_in   = head_data[4*COORD_BITS-1:2*COORD_BITS];
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            bot_sq_in  = $unsigned(bot_prod);
            top_sq_in  = $unsigned(top_prod);
            operand_in = rsq_ff;
            rem_in     = '0;
            root_in    = '0;
            step_in    = '0;
            phase_in   = PH_RADIUS;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            operand_in = {operand_ff[SQ_BITS-3:0], 2'b00};
            rem_in     = rem_next;
            root_in    = root_next;
            step_in    = STEP_BITS'(step_ff + 1'b1);
            if (step_ff == LAST_STEP) begin
               step_in = '0;
               rem_in  = '0;
               root_in = '0;
               unique case (phase_ff)
                  PH_RADIUS: begin
                     radius_in  = root_next;
                     operand_in = rsq_ff + bot_sq_ff;
                     phase_in   = PH_BOTTOM;
                  end
                  PH_BOTTOM: begin
                     bot_in     = root_next + COORD_BITS'(1);
                     operand_in = rsq_ff + top_sq_ff;
                     phase_in   = PH_TOP;
                  end
                  PH_TOP: begin
                     top_in   = root_next + COORD_BITS'(1);
                     state_in = ST_DELIVER;
                  end
               endcase
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_low_in    = min_y_ff;
               rsp_high_in   = max_y_ff;
               rsp_radius_in = radius_ff;
               rsp_bot_in    = bot_ff;
               rsp_top_in    = top_ff;
               rsp_depth_in  = (top_ff > bot_ff) ? top_ff : bot_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_RADIUS;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      operand_ff    <= operand_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      min_y_ff      <= min_y_in;
      max_y_ff      <= max_y_in;
      rsq_ff        <= rsq_in;
      bot_sq_ff     <= bot_sq_in;
      top_sq_ff     <= top_sq_in;
      radius_ff     <= radius_in;
      bot_ff        <= bot_in;
      top_ff        <= top_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_radius_ff <= rsp_radius_in;
      rsp_bot_ff    <= rsp_bot_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_BITS'({rsp_depth_ff, rsp_top_ff, rsp_bot_ff, rsp_radius_ff,
                                  rsp_high_ff, rsp_low_ff});

   `VBC_ASSERT(a_depth_covers_edges, clock, reset,
      rsp_valid_ff |-> ((rsp_depth_ff >= rsp_bot_ff) && (rsp_depth_ff >= rsp_top_ff)))
   `VBC_ASSERT(a_radius_below_edge, clock, reset,
      rsp_valid_ff |-> ((rsp_radius_ff < rsp_bot_ff) && (rsp_radius_ff < rsp_top_ff)))
   `VBC_ASSERT(a_pop_only_idle, clock, reset, pop |=> (state_ff == ST_SQUARE))
endmodule
`default_nettype wire

// File: bench/testbench.sv
// self-checking testbench for the streaming vertex bounding cylinder block
module testbench;
   localparam int  COORD_BITS   = 16;
   localparam int  REQ_BITS     = ((3*COORD_BITS+7)/8)*8;
   localparam int  RSP_BITS     = ((6*COORD_BITS+7)/8)*8;
   localparam int  RANDOM_ITEMS = 1150;
   localparam int  CYCLE_LIMIT  = 600000;
   localparam int  DRAIN_CYCLES = 300;
   localparam int  N_DIRECTED   = 18;
   localparam logic signed [15:0] Y_MAX = 16'sh7FFF;
   localparam logic signed [15:0] Y_MIN = 16'sh8000;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               last;
   } vertex_type;

   typedef struct packed {
      logic signed [15:0] lowest_y;
      logic signed [15:0] highest_y;
      logic [15:0]        radius;
      logic [15:0]        bottom_edge;
      logic [15:0]        top_edge;
      logic [15:0]        max_depth;
   } cylinder_type;

   typedef struct packed {
      vertex_type   v;
      logic         typed;
      cylinder_type want;
   } vertex_row_type;

   // typed rows carry a result worked out by hand, the rest go through the predictor
   vertex_row_type vertex_table [N_DIRECTED] = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b1,
        '{16'sd0, 16'sd0, 16'd0, 16'd1, 16'd1, 16'd1}},
      '{'{Y_MIN, Y_MIN, Y_MIN, 1'b1}, 1'b1,
        '{Y_MIN, Y_MIN, 16'd46340, 16'd56756, 16'd56756, 16'd56756}},
      '{'{Y_MAX, Y_MAX, Y_MAX, 1'b1}, 1'b0, '0},
      '{'{Y_MIN, 16'sd0, 16'sd0, 1'b0}, 1'b0, '0},
      '{'{16'sd0, Y_MAX, 16'sd0, 1'b0}, 1'b0, '0},
      '{'{16'sd0, Y_MIN, Y_MAX, 1'b0}, 1'b0, '0},
      '{'{16'sd100, -16'sd5, -16'sd100, 1'b1}, 1'b0, '0},
      '{'{16'sd3, 16'sd4, 16'sd0, 1'b1}, 1'b1,
        '{16'sd4, 16'sd4, 16'd3, 16'd6, 16'd6, 16'd6}},
      '{'{16'sd1, -16'sd1, 16'sd1, 1'b0}, 1'b0, '0},
      '{'{-16'sd1, 16'sd1, -16'sd1, 1'b1}, 1'b0, '0},
      '{'{Y_MAX, Y_MIN, Y_MIN, 1'b0}, 1'b0, '0},
      '{'{Y_MIN, Y_MAX, Y_MAX, 1'b0}, 1'b0, '0},
      '{'{16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b0, '0},
      '{'{16'sd0, -16'sd7, 16'sd0, 1'b1}, 1'b0, '0},
      '{'{16'sd12345, -16'sd300, -16'sd23456, 1'b0}, 1'b0, '0},
      '{'{-16'sd23456, 16'sd300, 16'sd12345, 1'b1}, 1'b0, '0},
      '{'{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0}, 1'b0, '0},
      '{'{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b1}, 1'b0, '0}
   };

   string field_name [6] = '{"lowest_y", "highest_y", "radius",
                             "bottom_edge", "top_edge", "max_depth"};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;  // vert_x, vert_y, vert_z
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;       // lowest_y, highest_y, radius, bottom_edge,
                                         // top_edge, max_depth

   // running extremes of the model being gathered
   logic signed [15:0] run_min_y = Y_MAX;
   logic signed [15:0] run_max_y = Y_MIN;
   logic [31:0]        run_rsq   = '0;

   logic [RSP_BITS-1:0] pending_cylinders [$];

   int send_idle_pct = 22;
   int recv_idle_pct = 46;
   int cycle_count   = 0;
   int mismatches    = 0;
   int vertices_sent = 0;
   int models_sent   = 0;
   int cylinders_checked = 0;

   vertex_bounding_cylinder #(.COORD_BITS(COORD_BITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint floor_root(input longint n);
      longint res;
      longint trial;
      res = 0;
      for (int b = 17; b >= 0; b--) begin
         trial = res | (longint'(1) << b);
         if (trial * trial <= n) res = trial;
      end
      return res;
   endfunction

   function automatic logic [RSP_BITS-1:0] to_tdata(input cylinder_type c);
      return {c.max_depth, c.top_edge, c.bottom_edge, c.radius, c.highest_y, c.lowest_y};
   endfunction

   // folds one vertex into the running extremes, returns 1 when a model closes
   function automatic bit fold_vertex(input vertex_type v, output cylinder_type c);
      longint sx, sz, span, lo, hi, rsq;
      c  = '0;
      sx = longint'(v.x);
      sz = longint'(v.z);
      if (v.y < run_min_y) run_min_y = v.y;
      if (v.y > run_max_y) run_max_y = v.y;
      span = sx * sx + sz * sz;
      if (span > longint'(run_rsq)) run_rsq = span[31:0];
      if (!v.last) return 1'b0;
      rsq = longint'(run_rsq);
      lo  = longint'(run_min_y);
      hi  = longint'(run_max_y);
      c.lowest_y    = run_min_y;
      c.highest_y   = run_max_y;
      c.radius      = 16'(floor_root(rsq));
      c.bottom_edge = 16'(floor_root(rsq + lo * lo) + 1);
      c.top_edge    = 16'(floor_root(rsq + hi * hi) + 1);
      c.max_depth   = (c.top_edge > c.bottom_edge) ? c.top_edge : c.bottom_edge;
      run_min_y = Y_MAX;
      run_max_y = Y_MIN;
      run_rsq   = '0;
      return 1'b1;
   endfunction

   function automatic logic [15:0] pick_coord();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         1, 2: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic drive_vertex(input vertex_type v, input logic typed,
                               input cylinder_type want);
      cylinder_type c;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v.z, v.y, v.x};
      req_tlast  <= v.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (fold_vertex(v, c)) begin
         pending_cylinders.push_back(to_tdata(typed ? want : c));
         models_sent++;
      end
      vertices_sent++;
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_cylinders.size() != 0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d cylinders outstanding",
                  cycle_count, pending_cylinders.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      logic [RSP_BITS-1:0] want;
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cylinders.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %h", rsp_tdata);
         end else begin
            want = pending_cylinders.pop_front();
            cylinders_checked++;
            if (want !== rsp_tdata) begin
               mismatches++;
               if (mismatches <= 10)
                  for (int f = 0; f < 6; f++)
                     if (want[f*16 +: 16] !== rsp_tdata[f*16 +: 16])
                        $display("cylinder %0d %s: expected %h, got %h", cylinders_checked,
                                 field_name[f], want[f*16 +: 16], rsp_tdata[f*16 +: 16]);
            end
         end
      end
   end

   initial begin
      vertex_type v;
      int         len;
      int         n_random;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++)
         drive_vertex(vertex_table[i].v, vertex_table[i].typed, vertex_table[i].want);
      hold_until_drained();

      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         case (n_random * 3 / RANDOM_ITEMS)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 46;
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            v.x    = pick_coord();
            v.y    = pick_coord();
            v.z    = pick_coord();
            v.last = (i == len - 1);
            drive_vertex(v, 1'b0, '0);
            n_random++;
         end
         if ($urandom_range(0, 39) == 0) hold_until_drained();
      end

      req_tvalid <= 1'b0;
      while (pending_cylinders.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d vertices in %0d models, %0d cylinders compared, %0d mismatches",
               vertices_sent, models_sent, cylinders_checked, mismatches);
      if (mismatches == 0 && pending_cylinders.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
